@@ rtl/core/text_console_character_engine_core_macros.svh @@
// assertion helpers shared by the console engine modules
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_CORE_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define TCCE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define TCCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  `TCCE_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `TCCE_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ rtl/core/tcce_pkg.sv @@
`timescale 1ns / 1ps

package tcce_pkg;

  // screen geometry
  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int NCELLS = ROWS * COLS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;

  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
  localparam logic [COL_W-1:0]  TAB_LIMIT  = COL_W'(COLS - 9);
  localparam logic [COL_W-1:0]  TAB_STEP   = COL_W'(8);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(NCELLS - COLS);
  localparam logic [ADDR_W-1:0] CELL_COUNT = ADDR_W'(NCELLS);

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF       = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;

  // item operations
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic put;       // apply the accepted character
    logic read;      // launch a cell read
    logic fill;      // blank sweep step
    logic scroll;    // scroll copy step
    logic load_out;  // capture a result beat
    logic out_ram;   // result carries the read cell
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_read;
    logic ff;
    logic scroll;
    logic fill_last;
    logic scroll_last;
  } status_t;

endpackage

@@ rtl/core/tcce_in_if.sv @@
`timescale 1ns / 1ps

interface tcce_in_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_index;

  modport source (output valid, output op, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input op, input char_code, input cell_index,
                  output ready);
endinterface

@@ rtl/core/tcce_out_if.sv @@
`timescale 1ns / 1ps

interface tcce_out_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, output cursor_row, output cursor_col, output cell_data,
                  input ready);
  modport sink   (input valid, input cursor_row, input cursor_col, input cell_data,
                  output ready);
endinterface

@@ rtl/core/tcce_datapath.sv @@
`timescale 1ns / 1ps
`include "text_console_character_engine_core_macros.svh"

module tcce_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcce_pkg::cmd_t              cmd_i,
  output tcce_pkg::status_t           status_o,
  input  logic                        op_i,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcce_pkg::ADDR_W-1:0] cell_index_i,
  input  logic                        cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata_i,
  output logic [tcce_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tcce_pkg::COL_W-1:0]  cursor_col_o,
  output logic [tcce_pkg::CELL_W-1:0] cell_data_o
);
  import tcce_pkg::*;

  logic [ATTR_W-1:0] attr_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] cnt_q;
  logic [CELL_W-1:0] mem [NCELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              rd_oob_q;

  logic [ROW_W:0]    nxt_row_w;
  logic [ROW_W-1:0]  nxt_row;
  logic [COL_W-1:0]  nxt_col;
  logic              is_print, is_ff, need_scroll;
  logic [ADDR_W-1:0] cur_addr;
  logic              we, re, rd_oob;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;
  logic              fill_last, scroll_last;

  // cursor move for the offered character
  always_comb begin
    nxt_row_w = {1'b0, row_q};
    nxt_col   = col_q;
    is_print  = 1'b0;
    is_ff     = 1'b0;
    if (char_code_i >= CH_PRINT_LO && char_code_i <= CH_PRINT_HI) begin
      is_print = 1'b1;
      if (col_q == COL_LAST) begin
        nxt_col   = '0;
        nxt_row_w = {1'b0, row_q} + (ROW_W+1)'(1);
      end else begin
        nxt_col = col_q + COL_W'(1);
      end
    end else begin
      case (char_code_i)
        CH_BS: begin
          if (col_q != '0) nxt_col = col_q - COL_W'(1);
        end
        CH_TAB: begin
          if (col_q <= TAB_LIMIT) nxt_col = col_q + TAB_STEP;
        end
        CH_LF: begin
          nxt_row_w = {1'b0, row_q} + (ROW_W+1)'(1);
          nxt_col   = '0;
        end
        CH_FF: begin
          is_ff     = 1'b1;
          nxt_row_w = '0;
          nxt_col   = '0;
        end
        CH_CR: begin
          nxt_col = '0;
        end
        default: begin
        end
      endcase
    end
    need_scroll = nxt_row_w >= (ROW_W+1)'(ROWS);
    nxt_row     = need_scroll ? ROW_LAST : nxt_row_w[ROW_W-1:0];
  end

  assign row_d = cmd_i.put ? nxt_row : row_q;
  assign col_d = cmd_i.put ? nxt_col : col_q;

  assign cur_addr = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);

  assign fill_last   = cnt_q == CELL_LAST;
  assign scroll_last = cnt_q == SCROLL_END;
  assign rd_oob      = cell_index_i >= CELL_COUNT;

  // memory port muxing
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {attr_q, char_code_i};
    re    = 1'b0;
    raddr = cell_index_i;
    if (cmd_i.fill) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = BLANK_CELL;
    end else if (cmd_i.scroll) begin
      // read one row ahead, write the cell fetched last cycle
      we    = cnt_q != '0;
      waddr = cnt_q - ADDR_W'(1);
      wdata = rdata_q;
      re    = !scroll_last;
      raddr = cnt_q + COLS_A;
    end else if (cmd_i.put) begin
      we = is_print;
    end else if (cmd_i.read) begin
      re = !rd_oob;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
      row_q  <= '0;
      col_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      row_q <= row_d;
      col_q <= col_d;
      if ((cmd_i.fill && fill_last) || (cmd_i.scroll && scroll_last)) begin
        cnt_q <= '0;
      end else if (cmd_i.fill || cmd_i.scroll) begin
        cnt_q <= cnt_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) rd_oob_q <= rd_oob;
    if (cmd_i.load_out) begin
      cursor_row_o <= row_d;
      cursor_col_o <= col_d;
      cell_data_o  <= (cmd_i.out_ram && !rd_oob_q) ? rdata_q : '0;
    end
  end

  assign status_o.op_read     = op_i == OP_READ;
  assign status_o.ff          = is_ff;
  assign status_o.scroll      = need_scroll;
  assign status_o.fill_last   = fill_last;
  assign status_o.scroll_last = scroll_last;

  `TCCE_ASSERT(a_row_in_range, clk_i, rst_ni, row_q <= ROW_LAST, "cursor row beyond last row")
  `TCCE_ASSERT(a_col_in_range, clk_i, rst_ni, col_q <= COL_LAST, "cursor column beyond last")
  `TCCE_ASSERT_IMPLY(a_one_sweep, clk_i, rst_ni, cmd_i.fill, !cmd_i.scroll && !cmd_i.put, "fill overlaps other memory traffic")

endmodule

@@ rtl/core/tcce_ctrl.sv @@
`timescale 1ns / 1ps
`include "text_console_character_engine_core_macros.svh"

module tcce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tcce_pkg::status_t status_i,
  output tcce_pkg::cmd_t    cmd_o
);
  import tcce_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          if (status_i.op_read) begin
            cmd_o.read = 1'b1;
            state_d    = ST_READ;
          end else begin
            cmd_o.put = 1'b1;
            if (status_i.ff) begin
              state_d = ST_FILL;
            end else if (status_i.scroll) begin
              state_d = ST_SCROLL;
            end else begin
              cmd_o.load_out = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        cmd_o.load_out = 1'b1;
        cmd_o.out_ram  = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SCROLL: begin
        cmd_o.scroll = 1'b1;
        if (status_i.scroll_last) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_last) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  `TCCE_ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, cmd_o.load_out, !out_valid_q || out_ready_i, "result beat overwritten")
  `TCCE_ASSERT_NEXT(a_put_result, clk_i, rst_ni, accept && !status_i.op_read && !status_i.ff && !status_i.scroll, out_valid_q, "plain put gave no result")
  `TCCE_ASSERT_NEXT(a_scroll_ends, clk_i, rst_ni, state_q == ST_SCROLL && status_i.scroll_last, state_q == ST_IDLE && out_valid_q, "scroll did not finish")

endmodule

@@ rtl/core/text_console_character_engine_core.sv @@
`timescale 1ns / 1ps
// channel   dir   beat contents
// in_if     in    op, char_code, cell_index
// out_if    out   cursor_row, cursor_col, cell_data
// cfg       in    cfg_we_i, cfg_wdata_i (text attribute)
//
// a printable or cursor-only character is answered from idle, a cell read via a read state
// a character that scrolls copies the rows up, one cell copied per cycle
// form feed blanks the store, one cell blanked per cycle
// these sweep rates come from the single-write, single-read screen memory
// after reset a clearing pass runs before the first beat is taken
// a waiting result stalls input only until out_if drains it

module text_console_character_engine_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tcce_in_if.sink                     in_if,
  tcce_out_if.source                  out_if,
  input  logic                        cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata_i
);
  import tcce_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: clearing pass, handshakes, sweep control
  tcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: cursor, attribute, screen memory, result register
  tcce_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (in_if.op),
    .char_code_i  (in_if.char_code),
    .cell_index_i (in_if.cell_index),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cursor_row_o (out_if.cursor_row),
    .cursor_col_o (out_if.cursor_col),
    .cell_data_o  (out_if.cell_data)
  );

endmodule

@@ bench/text_console_character_engine_core_tb.sv @@
`timescale 1ns / 1ps

module text_console_character_engine_core_tb;
  import tcce_pkg::*;

  // bytes outside the printable window and the top of the index space
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BELOW_PRT = CH_PRINT_LO - 8'd1;
  localparam logic [CHAR_W-1:0] CH_DEL       = CH_PRINT_HI + 8'd1;
  localparam logic [CHAR_W-1:0] CH_TOP       = 8'hFF;
  localparam logic [ADDR_W-1:0] ADDR_MAX     = {ADDR_W{1'b1}};

  // cycles left to the block after the last result: a full clearing pass plus margin
  localparam int SETTLE_CYCLES = 2100;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] data;
  } console_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcce_in_if  char_ch ();
  tcce_out_if view_ch ();

  text_console_character_engine_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (char_ch),
    .out_if      (view_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // shadow console: screen store, cursor and attribute as the block should hold them
  logic [CELL_W-1:0] screen_shadow [NCELLS];
  logic [ROW_W-1:0]  shadow_row;
  logic [COL_W-1:0]  shadow_col;
  logic [ATTR_W-1:0] shadow_attr;

  console_beat_t pending_views [$];

  int unsigned error_count;
  int unsigned put_count, read_count, scroll_count, clear_count, oob_count;
  bit          steady_flow;  // when set neither side idles

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, far beyond the slowest legal run (every beat a clear plus long stalls)
  initial begin
    #(250_000_000);
    $display("text_console_character_engine_core regression: fail");
    $finish;
  end

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // apply one put to the shadow console, following the character rules
  task automatic shadow_put(input logic [CHAR_W-1:0] ch);
    int r, c;
    r = shadow_row;
    c = shadow_col;
    put_count++;
    if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
      screen_shadow[r * COLS + c] = {shadow_attr, ch};
      if (c == COLS - 1) begin
        c = 0;
        r = r + 1;
      end else begin
        c = c + 1;
      end
    end else begin
      case (ch)
        CH_BS: begin
          if (c != 0) c = c - 1;
        end
        CH_TAB: begin
          if (c <= COLS - 9) c = c + 8;
        end
        CH_LF: begin
          r = r + 1;
          c = 0;
        end
        CH_FF: begin
          for (int i = 0; i < NCELLS; i++) screen_shadow[i] = BLANK_CELL;
          r = 0;
          c = 0;
          clear_count++;
        end
        CH_CR: begin
          c = 0;
        end
        default: begin
          // ignored byte, cursor stays
        end
      endcase
    end
    // past the last row: rows 1..ROWS-1 move up, bottom row keeps its old cells
    if (r >= ROWS) begin
      for (int i = 0; i < NCELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
      r = ROWS - 1;
      scroll_count++;
    end
    shadow_row = ROW_W'(r);
    shadow_col = COL_W'(c);
  endtask

  // one process watches both channels at each edge: accepted input beats
  // are predicted first, then the accepted result beat is checked
  always @(posedge clk_i) begin
    console_beat_t want;
    if (rst_ni) begin
      if (cfg_we) shadow_attr = cfg_wdata;
      if (char_ch.valid && char_ch.ready) begin
        want.data = '0;
        if (char_ch.op == OP_PUT) begin
          shadow_put(char_ch.char_code);
        end else begin
          read_count++;
          if (char_ch.cell_index < CELL_COUNT) want.data = screen_shadow[char_ch.cell_index];
          else oob_count++;
        end
        want.row = shadow_row;
        want.col = shadow_col;
        pending_views.push_back(want);
      end
      if (view_ch.valid && view_ch.ready) begin
        if (pending_views.size() == 0) begin
          $display("%0t: result beat with nothing expected: row %0d col %0d data %h",
                   $time, view_ch.cursor_row, view_ch.cursor_col, view_ch.cell_data);
          error_count++;
        end else begin
          want = pending_views.pop_front();
          if (view_ch.cursor_row !== want.row) begin
            $display("%0t: cursor_row mismatch: expected %0d actual %0d",
                     $time, want.row, view_ch.cursor_row);
            error_count++;
          end
          if (view_ch.cursor_col !== want.col) begin
            $display("%0t: cursor_col mismatch: expected %0d actual %0d",
                     $time, want.col, view_ch.cursor_col);
            error_count++;
          end
          if (view_ch.cell_data !== want.data) begin
            $display("%0t: cell_data mismatch: expected %h actual %h",
                     $time, want.data, view_ch.cell_data);
            error_count++;
          end
        end
      end
    end
  end

  // result side backpressure: ready in runs, broken by random stalls
  initial begin
    int unsigned g;
    view_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      view_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      g = pick_gap();
      if (g != 0) begin
        view_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // offer one beat and return at the edge where it is taken; valid stays
  // high so that a back-to-back beat can follow in the same step
  task automatic send_beat(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] idx);
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      char_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    char_ch.valid      <= 1'b1;
    char_ch.op         <= op;
    char_ch.char_code  <= ch;
    char_ch.cell_index <= idx;
    do @(posedge clk_i); while (!char_ch.ready);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_beat(OP_PUT, ch, ADDR_W'($urandom_range(0, ADDR_MAX)));
  endtask

  task automatic read_cell(input logic [ADDR_W-1:0] idx);
    send_beat(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  // stop sending, let every result arrive, then give the block time to finish any sweep
  task automatic drain_views();
    char_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // block is idle here, so the attribute write cannot race a beat
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // mostly reads near the cursor row, some anywhere, a few past the end
  function automatic logic [ADDR_W-1:0] pick_read_index();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return ADDR_W'(shadow_row * COLS + $urandom_range(0, COLS - 1));
    if (r < 9) return ADDR_W'($urandom_range(0, NCELLS - 1));
    return ADDR_W'($urandom_range(NCELLS, ADDR_MAX));
  endfunction

  // blank store after the clearing pass, including the index edges
  task automatic test_reset_reads();
    read_cell('0);
    read_cell(CELL_LAST);
    read_cell(ADDR_MAX);
    drain_views();
  endtask

  // printable window edges with the reset attribute, bytes just outside are ignored
  task automatic test_print_window();
    put_char(CH_PRINT_LO);
    put_char(CH_PRINT_HI);
    put_char(CH_BELOW_PRT);
    put_char(CH_DEL);
    put_char(CH_TOP);
    read_cell(ADDR_W'(1));
    drain_views();
  endtask

  // backspace down to column 0 and once more at column 0, then newline
  task automatic test_cursor_moves();
    put_char(CH_BS);
    put_char(CH_BS);
    put_char(CH_BS);
    put_char(CH_LF);
    drain_views();
  endtask

  // tab steps up to column 72, refused there, allowed from 71; then wrap off column 79
  task automatic test_tab_and_wrap();
    repeat (9) put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_BS);
    put_char(CH_TAB);
    put_char(CH_PRINT_HI);
    put_char(CH_CR);
    drain_views();
  endtask

  // form feed blanks everything regardless of attribute and homes the cursor
  task automatic test_form_feed();
    put_char(CH_FF);
    read_cell(ADDR_W'(COLS + 1));
    drain_views();
  endtask

  // random console traffic: text lines, reads, cursor codes, noise, newline
  // bursts and rare clears; pauses once mid-phase until all results are in
  task automatic test_text_phase(input logic [ATTR_W-1:0] attr, input int items,
                                 input bit no_idle);
    int sent, len, kind, tail;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    write_attribute(attr);
    steady_flow = no_idle;
    while (sent < items) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // a line of text, sometimes checked as it goes
        len = $urandom_range(0, 90);
        for (int i = 0; i < len; i++) begin
          put_char(CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
          if ($urandom_range(0, 9) == 0) read_cell(pick_read_index());
        end
        sent += len;
        tail = $urandom_range(0, 9);
        if (tail < 5) begin
          put_char(CH_LF);
          sent++;
        end else if (tail < 8) begin
          put_char(CH_CR);
          put_char(CH_LF);
          sent += 2;
        end
      end else if (kind < 65) begin
        len = $urandom_range(1, 6);
        repeat (len) read_cell(pick_read_index());
        sent += len;
      end else if (kind < 80) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          case ($urandom_range(0, 2))
            0:       put_char(CH_BS);
            1:       put_char(CH_TAB);
            default: put_char(CH_CR);
          endcase
        end
        sent += len;
      end else if (kind < 94) begin
        // noise: any op, any byte, any index
        len = $urandom_range(1, 4);
        repeat (len) send_beat(logic'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                               ADDR_W'($urandom_range(0, ADDR_MAX)));
        sent += len;
      end else if (kind < 99) begin
        // newline burst, scrolls once the cursor sits on the last row
        len = $urandom_range(1, 5);
        repeat (len) put_char(CH_LF);
        read_cell(ADDR_W'((ROWS - 2) * COLS + $urandom_range(0, COLS - 1)));
        sent += len + 1;
      end else begin
        put_char(CH_FF);
        read_cell(pick_read_index());
        sent += 2;
      end
      if (!paused && sent >= items / 2) begin
        drain_views();
        paused = 1'b1;
      end
    end
    drain_views();
    steady_flow = 1'b0;
  endtask

  initial begin
    error_count  = 0;
    put_count    = 0;
    read_count   = 0;
    scroll_count = 0;
    clear_count  = 0;
    oob_count    = 0;
    steady_flow  = 1'b0;
    for (int i = 0; i < NCELLS; i++) screen_shadow[i] = BLANK_CELL;
    shadow_row  = '0;
    shadow_col  = '0;
    shadow_attr = ATTR_RESET;

    char_ch.valid      <= 1'b0;
    char_ch.op         <= OP_PUT;
    char_ch.char_code  <= CH_NUL;
    char_ch.cell_index <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    rst_ni             <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset attribute still in force
    test_reset_reads();
    test_print_window();
    test_cursor_moves();
    test_tab_and_wrap();
    test_form_feed();

    // random part across attribute settings, extremes first
    test_text_phase(8'h00, 300, 1'b0);
    test_text_phase(8'hFF, 300, 1'b0);
    test_text_phase(ATTR_W'($urandom_range(0, 255)), 300, 1'b1);
    test_text_phase(ATTR_W'($urandom_range(0, 255)), 300, 1'b0);
    test_text_phase(ATTR_RESET, 300, 1'b0);

    $display("covered %0d puts and %0d reads (%0d past the store end)",
             put_count, read_count, oob_count);
    $display("with %0d scrolls, %0d screen clears and five attribute settings",
             scroll_count, clear_count);
    if (error_count == 0) begin
      $display("text_console_character_engine_core regression: pass");
    end else begin
      $display("text_console_character_engine_core regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/tcce_in_if.sv
rtl/core/tcce_out_if.sv
rtl/core/tcce_datapath.sv
rtl/core/tcce_ctrl.sv
rtl/core/text_console_character_engine_core.sv
bench/text_console_character_engine_core_tb.sv
